// File: sv/ksct_pkg.sv
// Shared types, codes and constants of the keyboard scancode translator.
package ksct_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF  = 128;
  localparam int unsigned MNEMONIC_CHARS_DEF = 64;

  localparam int unsigned OP_W    = 3;
  localparam int unsigned CODE_W  = 9;
  localparam int unsigned IPOS_W  = 6;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned S_TDATA_W = 24;
  localparam int unsigned M_TDATA_W = 8;

  localparam logic [CODE_W-1:0] KEY_SHIFT_PRESS   = 9'd200;
  localparam logic [CODE_W-1:0] KEY_SHIFT_RELEASE = 9'd300;
  localparam logic [CODE_W-1:0] KEY_CTRL_PRESS    = 9'd201;
  localparam logic [CODE_W-1:0] KEY_CTRL_RELEASE  = 9'd301;
  localparam logic [CODE_W-1:0] KEY_ALT_PRESS     = 9'd202;
  localparam logic [CODE_W-1:0] KEY_ALT_RELEASE   = 9'd302;

  localparam logic [BYTE_W-1:0] CHAR_DIGIT_ZERO = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_DIGIT_NINE = 8'h39;

  typedef enum logic [OP_W-1:0] {
    OP_KEY       = 3'd0,
    OP_WR_PLAIN  = 3'd1,
    OP_WR_SHIFT  = 3'd2,
    OP_WR_PMNEM  = 3'd3,
    OP_WR_SMNEM  = 3'd4
  } ksct_op_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_TABLE = 2'd0,
    KIND_ALT   = 2'd1,
    KIND_MNEM  = 2'd2
  } ksct_kind_e;

  // What the held item asks for, given the modifier flags.
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_WRITE,
    ACT_SHIFT,
    ACT_CTRL,
    ACT_ALT_PRESS,
    ACT_ALT_RELEASE,
    ACT_CHAR,
    ACT_DIGIT,
    ACT_MNEM
  } ksct_act_e;

  typedef enum logic [1:0] {
    EMIT_CHAR,
    EMIT_ACC,
    EMIT_PENDING
  } ksct_emit_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_CHAR,
    ST_DIGIT,
    ST_ALT_OUT,
    ST_MN_FIRST,
    ST_MN_NEXT,
    ST_MN_LAST
  } ksct_state_e;

  typedef struct packed {
    logic       load_item;
    logic       clear_step;
    logic       tbl_write;
    logic       tgl_shift;
    logic       tgl_ctrl;
    logic       tgl_alt;
    logic       clear_acc;
    logic       feed_digit;
    logic       char_read;
    logic       mn_read_first;
    logic       mn_read_next;
    logic       latch_pending;
    logic       emit;
    ksct_emit_e emit_sel;
    logic       emit_last;
  } ksct_cmd_t;

  typedef struct packed {
    ksct_act_e act;
    logic      clear_done;
    logic      out_free;
    logic      mn_zero;
    logic      pos_last;
  } ksct_sts_t;

endpackage

// File: sv/keyboard_scancode_translator_core.sv
// Top level of the keyboard scancode translator.
//
// Input beats arrive on the s_axis channel: tuser carries the operation (key
// event or one of four table writes) and tdata the scancode, mnemonic byte
// position and data byte. Key events produce character beats on m_axis; the
// last beat caused by one input beat has tlast set, and tuser tells whether
// the byte came from a character table, the alt accumulator or a mnemonic.
// The cfg channel writes the scan table size; it is always ready.
// An input beat is taken in the idle state and decoded in the next cycle.
// Table writes and modifier keys finish there. A plain or shifted character
// is read there and emitted from ST_CHAR; an alt digit is read there and fed
// to the accumulator from ST_DIGIT; an alt release emits from ST_ALT_OUT. A
// mnemonic takes one table read per byte; MNEMONIC_CHARS sets its worst case.
// Results pass through a one-beat output register, so the next input beat is
// accepted while the last result of the previous one still waits; when the
// receiver stalls a longer run, the sequencer holds until the register frees.
// After reset a clearing pass zeroes all tables, one entry a cycle, over all
// TABLE_ENTRIES times 2**clog2(MNEMONIC_CHARS) addresses (8192 with the default
// sizes); s_axis_tready stays low during it, while cfg writes are still taken.
module keyboard_scancode_translator_core import ksct_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES  = TABLE_ENTRIES_DEF,
  parameter int unsigned MNEMONIC_CHARS = MNEMONIC_CHARS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // tdata: scancode [8:0], char_position [14:9], data_byte [22:15], zero [23]
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // tuser: operation [2:0]
  input  logic [OP_W-1:0]      s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // tdata: out_char [7:0]
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // tuser: out_kind [1:0]
  output logic [KIND_W-1:0]    m_axis_tuser,
  output logic                 m_axis_tlast,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [BYTE_W-1:0]    cfg_data_i
);

  ksct_cmd_t cmd;
  ksct_sts_t sts;

  // The size register can be written in any cycle.
  assign cfg_ready_o = 1'b1;

  ksct_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ksct_dp #(
    .TABLE_ENTRIES  (TABLE_ENTRIES),
    .MNEMONIC_CHARS (MNEMONIC_CHARS)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .m_tready_i  (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_char_o  (m_axis_tdata),
    .out_kind_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

endmodule

// File: sv/ksct_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ksct_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/ksct_dp.sv
// Datapath: held item, modifier flags, accumulator, tables and output register.
module ksct_dp import ksct_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES  = TABLE_ENTRIES_DEF,
  parameter int unsigned MNEMONIC_CHARS = MNEMONIC_CHARS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [S_TDATA_W-1:0] s_tdata_i,
  input  logic [OP_W-1:0]      s_tuser_i,
  input  logic                 cfg_valid_i,
  input  logic [BYTE_W-1:0]    cfg_data_i,
  input  ksct_cmd_t            cmd_i,
  output ksct_sts_t            sts_o,
  input  logic                 m_tready_i,
  output logic                 out_valid_o,
  output logic [BYTE_W-1:0]    out_char_o,
  output logic [KIND_W-1:0]    out_kind_o,
  output logic                 out_last_o
);

  localparam int unsigned RowW    = $clog2(TABLE_ENTRIES);
  localparam int unsigned PosW    = $clog2(MNEMONIC_CHARS);
  localparam int unsigned MnAw    = RowW + PosW;
  localparam int unsigned MnDepth = TABLE_ENTRIES * (2 ** PosW);

  logic [OP_W-1:0]   op_q;
  logic [CODE_W-1:0] code_q;
  logic [IPOS_W-1:0] ipos_q;
  logic [BYTE_W-1:0] data_q;
  logic [BYTE_W-1:0] size_q;
  logic              shift_q, ctrl_q, alt_q;
  logic [BYTE_W-1:0] acc_q, acc_d;
  logic [MnAw-1:0]   clr_q;
  logic [PosW-1:0]   mn_pos_q, mn_pos_d;
  logic [BYTE_W-1:0] pending_q;
  logic              out_valid_q, out_last_q;
  logic [BYTE_W-1:0] out_char_q;
  logic [KIND_W-1:0] out_kind_q;

  logic [RowW-1:0]   row;
  logic              row_ok, pos_ok, key_ok;
  ksct_act_e         act;
  logic [BYTE_W-1:0] pc_rdata, sc_rdata, pm_rdata, sm_rdata;
  logic [BYTE_W-1:0] char_rdata, mn_rdata;
  logic [BYTE_W-1:0] digit, acc_x10;
  logic              clearing, mn_re;
  logic              pc_we, sc_we, pm_we, sm_we;
  logic [RowW-1:0]   ch_waddr;
  logic [MnAw-1:0]   mn_waddr;
  logic [BYTE_W-1:0] wdata;

  assign row = code_q[RowW-1:0];

  // Classification of the held item.
  always_comb begin
    row_ok = code_q < CODE_W'(TABLE_ENTRIES);
    pos_ok = {1'b0, ipos_q} < (IPOS_W + 1)'(MNEMONIC_CHARS);
    key_ok = row_ok && (code_q < {1'b0, size_q});
    act    = ACT_NONE;
    unique case (op_q)
      OP_KEY: begin
        priority if (code_q == KEY_SHIFT_PRESS || code_q == KEY_SHIFT_RELEASE) begin
          act = ACT_SHIFT;
        end else if (code_q == KEY_CTRL_PRESS || code_q == KEY_CTRL_RELEASE) begin
          act = ACT_CTRL;
        end else if (code_q == KEY_ALT_PRESS) begin
          act = ACT_ALT_PRESS;
        end else if (code_q == KEY_ALT_RELEASE) begin
          act = ACT_ALT_RELEASE;
        end else if (key_ok) begin
          unique case ({alt_q, ctrl_q})
            2'b00:   act = ACT_CHAR;
            2'b01:   act = ACT_MNEM;
            2'b10:   act = ACT_DIGIT;
            default: act = ACT_NONE;
          endcase
        end else begin
          act = ACT_NONE;
        end
      end
      OP_WR_PLAIN, OP_WR_SHIFT: act = row_ok ? ACT_WRITE : ACT_NONE;
      OP_WR_PMNEM, OP_WR_SMNEM: act = (row_ok && pos_ok) ? ACT_WRITE : ACT_NONE;
      default: act = ACT_NONE;
    endcase
  end

  // Table ports; the clearing pass zeroes all four tables together.
  assign clearing = cmd_i.clear_step;
  assign wdata    = clearing ? '0 : data_q;
  assign ch_waddr = clearing ? clr_q[MnAw-1:PosW] : row;
  assign mn_waddr = clearing ? clr_q : {row, ipos_q[PosW-1:0]};
  assign pc_we    = clearing || (cmd_i.tbl_write && op_q == OP_WR_PLAIN);
  assign sc_we    = clearing || (cmd_i.tbl_write && op_q == OP_WR_SHIFT);
  assign pm_we    = clearing || (cmd_i.tbl_write && op_q == OP_WR_PMNEM);
  assign sm_we    = clearing || (cmd_i.tbl_write && op_q == OP_WR_SMNEM);
  assign mn_re    = cmd_i.mn_read_first || cmd_i.mn_read_next;
  assign mn_pos_d = cmd_i.mn_read_first ? '0 : mn_pos_q + PosW'(1);

  ksct_ram #(.WIDTH(BYTE_W), .DEPTH(TABLE_ENTRIES)) u_plain_chars (
    .clk_i, .we_i(pc_we), .waddr_i(ch_waddr), .wdata_i(wdata),
    .re_i(cmd_i.char_read), .raddr_i(row), .rdata_o(pc_rdata)
  );
  ksct_ram #(.WIDTH(BYTE_W), .DEPTH(TABLE_ENTRIES)) u_shifted_chars (
    .clk_i, .we_i(sc_we), .waddr_i(ch_waddr), .wdata_i(wdata),
    .re_i(cmd_i.char_read), .raddr_i(row), .rdata_o(sc_rdata)
  );
  ksct_ram #(.WIDTH(BYTE_W), .DEPTH(MnDepth)) u_plain_mnems (
    .clk_i, .we_i(pm_we), .waddr_i(mn_waddr), .wdata_i(wdata),
    .re_i(mn_re), .raddr_i({row, mn_pos_d}), .rdata_o(pm_rdata)
  );
  ksct_ram #(.WIDTH(BYTE_W), .DEPTH(MnDepth)) u_shifted_mnems (
    .clk_i, .we_i(sm_we), .waddr_i(mn_waddr), .wdata_i(wdata),
    .re_i(mn_re), .raddr_i({row, mn_pos_d}), .rdata_o(sm_rdata)
  );

  assign char_rdata = shift_q ? sc_rdata : pc_rdata;
  assign mn_rdata   = shift_q ? sm_rdata : pm_rdata;

  // Decimal accumulation, kept modulo 256 by the 8-bit width.
  always_comb begin
    digit   = char_rdata - CHAR_DIGIT_ZERO;
    acc_x10 = {acc_q[4:0], 3'b000} + {acc_q[6:0], 1'b0};
    acc_d   = acc_q;
    if (cmd_i.clear_acc) begin
      acc_d = '0;
    end else if (cmd_i.feed_digit && char_rdata >= CHAR_DIGIT_ZERO &&
                 char_rdata <= CHAR_DIGIT_NINE) begin
      acc_d = acc_x10 + digit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q      <= '0;
      shift_q     <= 1'b0;
      ctrl_q      <= 1'b0;
      alt_q       <= 1'b0;
      acc_q       <= '0;
      clr_q       <= '0;
      mn_pos_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        size_q <= cfg_data_i;
      end
      if (cmd_i.tgl_shift) begin
        shift_q <= ~shift_q;
      end
      if (cmd_i.tgl_ctrl) begin
        ctrl_q <= ~ctrl_q;
      end
      if (cmd_i.tgl_alt) begin
        alt_q <= ~alt_q;
      end
      acc_q <= acc_d;
      if (cmd_i.clear_step) begin
        clr_q <= clr_q + MnAw'(1);
      end
      if (mn_re) begin
        mn_pos_q <= mn_pos_d;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_q   <= s_tuser_i;
      code_q <= s_tdata_i[CODE_W-1:0];
      ipos_q <= s_tdata_i[CODE_W +: IPOS_W];
      data_q <= s_tdata_i[CODE_W+IPOS_W +: BYTE_W];
    end
    if (cmd_i.latch_pending) begin
      pending_q <= mn_rdata;
    end
    if (cmd_i.emit) begin
      out_last_q <= cmd_i.emit_last;
      unique case (cmd_i.emit_sel)
        EMIT_CHAR: begin
          out_char_q <= char_rdata;
          out_kind_q <= KIND_TABLE;
        end
        EMIT_ACC: begin
          out_char_q <= acc_q;
          out_kind_q <= KIND_ALT;
        end
        EMIT_PENDING: begin
          out_char_q <= pending_q;
          out_kind_q <= KIND_MNEM;
        end
        default: begin
          out_char_q <= pending_q;
          out_kind_q <= KIND_MNEM;
        end
      endcase
    end
  end

  assign sts_o.act        = act;
  assign sts_o.clear_done = clr_q == MnAw'(MnDepth - 1);
  assign sts_o.out_free   = !out_valid_q || m_tready_i;
  assign sts_o.mn_zero    = mn_rdata == '0;
  assign sts_o.pos_last   = mn_pos_q == PosW'(MNEMONIC_CHARS - 1);

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_kind_o  = out_kind_q;
  assign out_last_o  = out_last_q;

endmodule

// File: sv/ksct_ctrl.sv
// Controller state machine: sequences clearing, decoding, lookups and emission.
module ksct_ctrl import ksct_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  ksct_sts_t sts_i,
  output ksct_cmd_t cmd_o
);

  ksct_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.emit_sel = EMIT_CHAR;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.clear_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_d = ST_IDLE;
        unique case (sts_i.act)
          ACT_WRITE:       cmd_o.tbl_write = 1'b1;
          ACT_SHIFT:       cmd_o.tgl_shift = 1'b1;
          ACT_CTRL:        cmd_o.tgl_ctrl  = 1'b1;
          ACT_ALT_PRESS:   cmd_o.tgl_alt   = 1'b1;
          ACT_ALT_RELEASE: state_d = ST_ALT_OUT;
          ACT_CHAR: begin
            cmd_o.char_read = 1'b1;
            state_d = ST_CHAR;
          end
          ACT_DIGIT: begin
            cmd_o.char_read = 1'b1;
            state_d = ST_DIGIT;
          end
          ACT_MNEM: begin
            cmd_o.mn_read_first = 1'b1;
            state_d = ST_MN_FIRST;
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_CHAR: begin
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_sel  = EMIT_CHAR;
          cmd_o.emit_last = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_DIGIT: begin
        cmd_o.feed_digit = 1'b1;
        state_d = ST_IDLE;
      end
      ST_ALT_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_sel  = EMIT_ACC;
          cmd_o.emit_last = 1'b1;
          cmd_o.clear_acc = 1'b1;
          cmd_o.tgl_alt   = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_MN_FIRST: begin
        if (sts_i.mn_zero) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.latch_pending = 1'b1;
          if (sts_i.pos_last) begin
            state_d = ST_MN_LAST;
          end else begin
            cmd_o.mn_read_next = 1'b1;
            state_d = ST_MN_NEXT;
          end
        end
      end
      ST_MN_NEXT: begin
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_sel  = EMIT_PENDING;
          cmd_o.emit_last = sts_i.mn_zero;
          if (sts_i.mn_zero) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.latch_pending = 1'b1;
            if (sts_i.pos_last) begin
              state_d = ST_MN_LAST;
            end else begin
              cmd_o.mn_read_next = 1'b1;
            end
          end
        end
      end
      ST_MN_LAST: begin
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_sel  = EMIT_PENDING;
          cmd_o.emit_last = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// File: tb/sv/ksct_char_checker.sv
`timescale 1ns / 100ps
// Checker that predicts the character beats of the scancode translator and compares them.
module ksct_char_checker import ksct_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  input  logic [OP_W-1:0]      s_axis_tuser,
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [M_TDATA_W-1:0] m_axis_tdata,
  input  logic [KIND_W-1:0]    m_axis_tuser,
  input  logic                 m_axis_tlast,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_o,
  input  logic [BYTE_W-1:0]    cfg_data_i,
  output int                   fail_count_o,
  output int                   chars_pending_o
);

  localparam int unsigned RowW = $clog2(TABLE_ENTRIES_DEF);

  typedef struct {
    logic [BYTE_W-1:0] ch;
    ksct_kind_e        kind;
    logic              last;
  } char_beat_t;

  logic [BYTE_W-1:0] table_size;
  logic              shift_on, ctrl_on, alt_on;
  logic [BYTE_W-1:0] alt_code;
  logic [BYTE_W-1:0] plain_tab [TABLE_ENTRIES_DEF];
  logic [BYTE_W-1:0] shift_tab [TABLE_ENTRIES_DEF];
  logic [BYTE_W-1:0] plain_mnem [TABLE_ENTRIES_DEF][MNEMONIC_CHARS_DEF];
  logic [BYTE_W-1:0] shift_mnem [TABLE_ENTRIES_DEF][MNEMONIC_CHARS_DEF];
  char_beat_t        expected_chars [$];
  int                fails;

  function automatic void push_char(logic [BYTE_W-1:0] ch, ksct_kind_e kind, logic last);
    char_beat_t beat;
    beat.ch   = ch;
    beat.kind = kind;
    beat.last = last;
    expected_chars.push_back(beat);
  endfunction

  // A mnemonic runs up to its first zero byte, or over the whole entry if it has none.
  function automatic void push_mnemonic(bit use_shift, logic [RowW-1:0] idx);
    int len;
    len = 0;
    while (len < MNEMONIC_CHARS_DEF &&
           (use_shift ? shift_mnem[idx][len] : plain_mnem[idx][len]) != '0)
      len++;
    for (int i = 0; i < len; i++)
      push_char(use_shift ? shift_mnem[idx][i] : plain_mnem[idx][i], KIND_MNEM, i == len - 1);
  endfunction

  function automatic void translate_beat(logic [OP_W-1:0] op, logic [CODE_W-1:0] code,
                                         logic [IPOS_W-1:0] pos, logic [BYTE_W-1:0] data);
    logic [BYTE_W-1:0] ch;
    logic [RowW-1:0]   row;
    row = code[RowW-1:0];
    unique case (op)
      OP_KEY: begin
        if (code == KEY_SHIFT_PRESS || code == KEY_SHIFT_RELEASE) begin
          shift_on = ~shift_on;
        end else if (code == KEY_CTRL_PRESS || code == KEY_CTRL_RELEASE) begin
          ctrl_on = ~ctrl_on;
        end else if (code == KEY_ALT_PRESS) begin
          alt_on = ~alt_on;
        end else if (code == KEY_ALT_RELEASE) begin
          push_char(alt_code, KIND_ALT, 1'b1);
          alt_code = '0;
          alt_on   = ~alt_on;
        end else if (code < table_size && code < TABLE_ENTRIES_DEF) begin
          unique case ({alt_on, ctrl_on, shift_on})
            3'b000: push_char(plain_tab[row], KIND_TABLE, 1'b1);
            3'b001: push_char(shift_tab[row], KIND_TABLE, 1'b1);
            3'b010: push_mnemonic(1'b0, row);
            3'b011: push_mnemonic(1'b1, row);
            3'b100, 3'b101: begin
              ch = shift_on ? shift_tab[row] : plain_tab[row];
              if (ch >= CHAR_DIGIT_ZERO && ch <= CHAR_DIGIT_NINE)
                alt_code = alt_code * 8'd10 + (ch - CHAR_DIGIT_ZERO);
            end
            default: ;  // ctrl together with alt does nothing
          endcase
        end
      end
      OP_WR_PLAIN: if (code < TABLE_ENTRIES_DEF) plain_tab[row] = data;
      OP_WR_SHIFT: if (code < TABLE_ENTRIES_DEF) shift_tab[row] = data;
      OP_WR_PMNEM:
        if (code < TABLE_ENTRIES_DEF && pos < MNEMONIC_CHARS_DEF) plain_mnem[row][pos] = data;
      OP_WR_SMNEM:
        if (code < TABLE_ENTRIES_DEF && pos < MNEMONIC_CHARS_DEF) shift_mnem[row][pos] = data;
      default: ;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    char_beat_t want;
    if (!rst_ni) begin
      table_size = '0;
      shift_on   = 1'b0;
      ctrl_on    = 1'b0;
      alt_on     = 1'b0;
      alt_code   = '0;
      fails      = 0;
      expected_chars.delete();
      for (int e = 0; e < TABLE_ENTRIES_DEF; e++) begin
        plain_tab[e] = '0;
        shift_tab[e] = '0;
        for (int p = 0; p < MNEMONIC_CHARS_DEF; p++) begin
          plain_mnem[e][p] = '0;
          shift_mnem[e][p] = '0;
        end
      end
    end else begin
      // Output beats always stem from inputs taken at earlier edges, so check first.
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_chars.size() == 0) begin
          $error("character beat 0x%02h kind %0d last %0b with no expectation waiting",
                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
          fails++;
        end else begin
          want = expected_chars.pop_front();
          if (m_axis_tdata !== want.ch) begin
            $error("out_char mismatch: expected 0x%02h, actual 0x%02h", want.ch, m_axis_tdata);
            fails++;
          end
          if (m_axis_tuser !== want.kind) begin
            $error("out_kind mismatch: expected %0d, actual %0d", want.kind, m_axis_tuser);
            fails++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("last_of_run mismatch: expected %0b, actual %0b", want.last, m_axis_tlast);
            fails++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o)
        table_size = cfg_data_i;
      if (s_axis_tvalid && s_axis_tready)
        translate_beat(s_axis_tuser, s_axis_tdata[8:0], s_axis_tdata[14:9], s_axis_tdata[22:15]);
    end
    fail_count_o    <= fails;
    chars_pending_o <= expected_chars.size();
  end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Testbench top that drives the scancode translator and reports the verdict.
module tb_top;
  import ksct_pkg::*;

  // Length of the one long receiver hold-off, in cycles.
  localparam int HOLD_CYCLES   = 400;
  // Input items in the random part, spread over four phases.
  localparam int RANDOM_ITEMS  = 160;
  // Quiet cycles after the last expected beat: covers the longest item that
  // still runs inside the block without producing anything.
  localparam int SETTLE_CYCLES = 80;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic [OP_W-1:0]      s_axis_tuser  = OP_KEY;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [KIND_W-1:0]    m_axis_tuser;
  logic                 m_axis_tlast;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [BYTE_W-1:0]    cfg_data_i    = '0;

  int fail_count;
  int chars_pending;

  // Idling controls, set per phase by the stimulus process.
  int tx_idle_pct   = 0;
  int rx_stall_pct  = 0;
  int hold_requests = 0;
  // Owned by the receiver process.
  int hold_grants   = 0;
  int hold_left     = 0;

  int items_sent    = 0;
  // The stimulus keeps its own view of the modifier flags, only to shape
  // well-formed key sequences; every press and release code toggles a flag.
  bit shift_on = 1'b0;
  bit ctrl_on  = 1'b0;
  bit alt_on   = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  keyboard_scancode_translator_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  ksct_char_checker char_check (
    .*,
    .fail_count_o    (fail_count),
    .chars_pending_o (chars_pending)
  );

  // Receiver: random stalls at the phase's rate, plus one long hold-off on
  // request. During the hold-off the output register and the sequencer fill
  // up, and the block must stop taking input beats.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (hold_grants != hold_requests) begin
      m_axis_tready <= 1'b0;
      hold_left     <= HOLD_CYCLES;
      hold_grants   <= hold_grants + 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Offers one input beat, with random idle cycles ahead of it, and waits until
  // it is taken. tvalid stays high into the next call unless a gap follows.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [CODE_W-1:0] code,
                           input logic [IPOS_W-1:0] pos, input logic [BYTE_W-1:0] data);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, data, pos, code};
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    // Unused operations are dropped by the block and do not count as items.
    if (op <= OP_WR_SMNEM) items_sent++;
    if (op == OP_KEY) begin
      if (code == KEY_SHIFT_PRESS || code == KEY_SHIFT_RELEASE) shift_on = ~shift_on;
      if (code == KEY_CTRL_PRESS || code == KEY_CTRL_RELEASE) ctrl_on = ~ctrl_on;
      if (code == KEY_ALT_PRESS || code == KEY_ALT_RELEASE) alt_on = ~alt_on;
    end
  endtask

  // Key events carry random filler in the unused fields, so those bits toggle too.
  task automatic press_key(input logic [CODE_W-1:0] code);
    send_item(OP_KEY, code, IPOS_W'($urandom_range(63)), BYTE_W'($urandom_range(255)));
  endtask

  // Brings the modifiers to the wanted set. Ctrl changes before alt, so a move from
  // ctrl to alt does not pass through ctrl with alt. Releasing alt emits its code.
  task automatic set_mods(input bit sh, input bit ct, input bit al);
    if (ctrl_on != ct) press_key(ctrl_on ? KEY_CTRL_RELEASE : KEY_CTRL_PRESS);
    if (alt_on != al) press_key(alt_on ? KEY_ALT_RELEASE : KEY_ALT_PRESS);
    if (shift_on != sh) press_key(shift_on ? KEY_SHIFT_RELEASE : KEY_SHIFT_PRESS);
  endtask

  task automatic write_table_size(input logic [BYTE_W-1:0] size);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= size;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Waits until every predicted beat has arrived, then lets the block finish
  // any item that produces nothing. The pending count is registered in the
  // checker, so the task lets it update before it looks at it.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (chars_pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // A key code that gets looked up under the given table size.
  function automatic logic [CODE_W-1:0] pick_key(input logic [BYTE_W-1:0] size);
    int lim;
    lim = (size < TABLE_ENTRIES_DEF) ? size : TABLE_ENTRIES_DEF;
    return CODE_W'($urandom_range(lim - 1));
  endfunction

  // One random phase. Most of it is well-formed key sequences with random
  // content: a mnemonic loaded and typed under ctrl, a character typed with or
  // without shift, or an alt code built from digit keys and sent by the alt
  // release. The rest is noise over all operations and the whole code range.
  task automatic run_phase(input logic [BYTE_W-1:0] size, input int tx_pct, input int rx_pct,
                           input bit pressure);
    int                goal;
    int                pick;
    int                len;
    int                digits;
    logic [CODE_W-1:0] k;
    logic [OP_W-1:0]   wr_op;
    logic [BYTE_W-1:0] ch;
    bit                sh;
    bit                long_mn;
    settle();
    write_table_size(size);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    if (pressure) hold_requests++;
    // Under pressure the phase opens with a full-length mnemonic, which keeps
    // the block busy against the held-off receiver.
    long_mn = pressure;
    goal = items_sent + RANDOM_ITEMS / 4;
    while (items_sent < goal) begin
      pick = $urandom_range(99);
      sh   = 1'($urandom_range(1));
      k    = pick_key(size);
      if (long_mn || pick < 25) begin
        set_mods(sh, 1'b1, 1'b0);
        len   = (long_mn || $urandom_range(99) < 3) ? MNEMONIC_CHARS_DEF : $urandom_range(6);
        wr_op = sh ? OP_WR_SMNEM : OP_WR_PMNEM;
        for (int i = 0; i < len; i++)
          send_item(wr_op, k, IPOS_W'(i), BYTE_W'($urandom_range(255, 1)));
        // A zero byte ends the mnemonic, whatever an earlier load left behind.
        if (len < MNEMONIC_CHARS_DEF) send_item(wr_op, k, IPOS_W'(len), 8'h00);
        press_key(k);
        long_mn = 1'b0;
      end else if (pick < 45) begin
        set_mods(sh, 1'b0, 1'b0);
        if ($urandom_range(1))
          send_item(sh ? OP_WR_SHIFT : OP_WR_PLAIN, k, IPOS_W'($urandom_range(63)),
                    BYTE_W'($urandom_range(255)));
        press_key(k);
      end else if (pick < 70) begin
        set_mods(sh, 1'b0, 1'b1);
        digits = $urandom_range(3, 1);
        repeat (digits) begin
          k  = pick_key(size);
          // Now and then a non-digit, which must leave the code alone.
          ch = BYTE_W'(($urandom_range(4) == 0) ? $urandom_range(255)
                                                : CHAR_DIGIT_ZERO + $urandom_range(9));
          send_item(sh ? OP_WR_SHIFT : OP_WR_PLAIN, k, IPOS_W'($urandom_range(63)), ch);
          press_key(k);
        end
        set_mods(sh, 1'b0, 1'b0);
      end else begin
        send_item(OP_W'($urandom_range(7)), CODE_W'($urandom_range(511)),
                  IPOS_W'($urandom_range(63)), BYTE_W'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. With a table size of zero no key is looked up, but the
    // modifier codes still act and alt release still emits its (zero) code.
    // The clearing pass after reset holds off these beats; the checker does
    // not care how long.
    write_table_size(8'd0);
    press_key(9'd0);
    send_item(OP_WR_PLAIN, 9'd5, 6'd0, "a");
    press_key(KEY_ALT_PRESS);
    press_key(KEY_ALT_RELEASE);
    settle();
    write_table_size(8'd128);
    press_key(9'd5);
    // A zero table character is still emitted.
    send_item(OP_WR_PLAIN, 9'd0, 6'd63, 8'h00);
    press_key(9'd0);
    // Shifted character at the top table entry.
    send_item(OP_WR_SHIFT, 9'd127, 6'd0, 8'hFF);
    press_key(KEY_SHIFT_PRESS);
    press_key(9'd127);
    // Codes past the tables give nothing.
    press_key(9'd128);
    press_key(9'd511);
    // Ctrl with shift on an empty mnemonic gives no beat at all.
    press_key(KEY_CTRL_PRESS);
    press_key(9'd127);
    // Plain mnemonic stops at its first zero byte, not at the last position.
    press_key(KEY_SHIFT_RELEASE);
    send_item(OP_WR_PMNEM, 9'd5, 6'd0, "x");
    send_item(OP_WR_PMNEM, 9'd5, 6'd63, "z");
    press_key(9'd5);
    // Ctrl with alt, then all three modifiers: nothing happens.
    press_key(KEY_ALT_PRESS);
    press_key(9'd5);
    press_key(KEY_SHIFT_PRESS);
    press_key(9'd5);
    // Alt alone: one digit, one non-digit, then the release emits the code.
    press_key(KEY_CTRL_RELEASE);
    press_key(KEY_SHIFT_RELEASE);
    send_item(OP_WR_PLAIN, 9'd7, 6'd0, "9");
    press_key(9'd7);
    press_key(9'd5);
    press_key(KEY_ALT_RELEASE);
    // Unused operations and writes out of range are dropped.
    for (int u = OP_WR_SMNEM + 1; u < 2 ** OP_W; u++)
      send_item(OP_W'(u), 9'd5, 6'd0, 8'h33);
    send_item(OP_WR_PLAIN, 9'd300, 6'd0, 8'h55);
    send_item(OP_WR_SMNEM, 9'd511, 6'd63, 8'hAA);
    press_key(9'd5);

    // Random phases over several table sizes and idling patterns.
    run_phase(8'd128, 0, 0, 1'b1);
    run_phase(8'd255, 60, 0, 1'b0);
    run_phase(BYTE_W'($urandom_range(127, 16)), 0, 60, 1'b0);
    run_phase(8'd128, 24, 24, 1'b0);

    settle();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Far beyond the slowest correct run, clearing pass included.
  initial begin
    #(10_000_000);
    $display("Test completed with failures");
    $finish;
  end

endmodule

// File: sim.f
sv/ksct_pkg.sv
sv/ksct_ram.sv
sv/ksct_dp.sv
sv/ksct_ctrl.sv
sv/keyboard_scancode_translator_core.sv
tb/sv/ksct_char_checker.sv
tb/sv/tb_top.sv
